[rtl/core/queue_machine_execute_unit_core_macros.svh]
// Assertion macros for the queue machine execute unit
`ifndef QUEUE_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH
`define QUEUE_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH

// implication checked every clock, off while in reset
`define QM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define QM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/qmeu_pkg.sv]
package qmeu_pkg;

    localparam int QueueDepthDef   = 1024;
    localparam int ProgramLinesDef = 4096;
    localparam int NumRegs         = 26;

    localparam int ValW  = 16;
    localparam int LineW = 13;
    localparam int RegW  = 5;

    localparam logic [4:0] ACT_PUSH   = 5'd0;
    localparam logic [4:0] ACT_ADD    = 5'd1;
    localparam logic [4:0] ACT_SUB    = 5'd2;
    localparam logic [4:0] ACT_MUL    = 5'd3;
    localparam logic [4:0] ACT_DIV    = 5'd4;
    localparam logic [4:0] ACT_MOD    = 5'd5;
    localparam logic [4:0] ACT_PUT    = 5'd6;
    localparam logic [4:0] ACT_GET    = 5'd7;
    localparam logic [4:0] ACT_PRNQ   = 5'd8;
    localparam logic [4:0] ACT_PRNR   = 5'd9;
    localparam logic [4:0] ACT_PRCQ   = 5'd10;
    localparam logic [4:0] ACT_PRCR   = 5'd11;
    localparam logic [4:0] ACT_NOP    = 5'd12;
    localparam logic [4:0] ACT_JMP    = 5'd13;
    localparam logic [4:0] ACT_JZ     = 5'd14;
    localparam logic [4:0] ACT_JEQ    = 5'd15;
    localparam logic [4:0] ACT_JGT    = 5'd16;
    localparam logic [4:0] ACT_QUIT   = 5'd17;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_NUM  = 2'd1;
    localparam logic [1:0] PK_CHR  = 2'd2;

    // ALU operation codes
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    typedef struct packed {
        logic            start;
        logic [1:0]      op;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic            done;
        logic [ValW-1:0] res;   // sum, difference, product or quotient
        logic [ValW-1:0] rem;
    } t_alu_rsp;

endpackage

[rtl/core/qmeu_alu.sv]
// Shared arithmetic unit: add/sub/mul with a registered result, divide one bit a cycle.
module qmeu_alu
    import qmeu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int CntW = $clog2(ValW + 1);

    logic            r_busy, n_busy;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [ValW-1:0] r_quo, n_quo;
    logic [ValW-1:0] r_rem, n_rem;
    logic [ValW-1:0] r_div, n_div;
    logic            r_done, n_done;
    logic [ValW-1:0] r_res, n_res;
    logic [ValW:0]   w_trial;
    logic [ValW:0]   w_shift;
    logic [2*ValW-1:0] w_prod;

    assign w_prod  = i_req.a * i_req.b;
    assign w_shift = {r_rem, r_quo[ValW-1]};
    assign w_trial = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_done = 1'b0;
        n_res  = r_res;
        if (i_req.start) begin
            case (i_req.op)
                ALU_ADD: begin
                    n_res  = i_req.a + i_req.b;
                    n_done = 1'b1;
                end
                ALU_SUB: begin
                    n_res  = i_req.a - i_req.b;
                    n_done = 1'b1;
                end
                ALU_MUL: begin
                    n_res  = w_prod[ValW-1:0];
                    n_done = 1'b1;
                end
                default: begin
                    n_busy = 1'b1;
                    n_cnt  = '0;
                    n_quo  = i_req.a;
                    n_rem  = '0;
                    n_div  = i_req.b;
                end
            endcase
        end else if (r_busy) begin
            if (w_trial[ValW]) begin
                n_rem = w_shift[ValW-1:0];
                n_quo = {r_quo[ValW-2:0], 1'b0};
            end else begin
                n_rem = w_trial[ValW-1:0];
                n_quo = {r_quo[ValW-2:0], 1'b1};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(ValW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_res  = n_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/core/qmeu_queue.sv]
// FIFO store with registered read; pop data appears the cycle after a pop.
module qmeu_queue
    import qmeu_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop,
    input  logic            i_push,
    input  logic [ValW-1:0] i_push_data,
    output logic [ValW-1:0] o_pop_data,
    output logic            o_empty,
    output logic            o_full
);

    localparam int AddrW = $clog2(QueueDepth);
    localparam int CntW  = $clog2(QueueDepth + 1);

    logic [ValW-1:0]  r_mem [QueueDepth];
    logic [AddrW-1:0] r_head, r_tail;
    logic [CntW-1:0]  r_count;
    logic             w_pop, w_push;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(QueueDepth));
    assign w_pop   = i_pop && !o_empty;
    assign w_push  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        o_pop_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_pop) begin
                r_head <= (r_head == AddrW'(QueueDepth - 1)) ? '0 : r_head + 1'b1;
            end
            if (w_push) begin
                r_tail <= (r_tail == AddrW'(QueueDepth - 1)) ? '0 : r_tail + 1'b1;
            end
            r_count <= r_count + CntW'(w_push) - CntW'(w_pop);
        end
    end

`include "queue_machine_execute_unit_core_macros.svh"

    `QM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CntW'(QueueDepth))
    `QM_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `QM_ASSERT_NXT(a_pop_shrinks, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

[rtl/core/queue_machine_execute_unit_core.sv]
// Add/sub/mul and div/mod go through the ALU; div/mod use its 16-step restoring
// divider.
// Throughput: one word at a time; ready only when idle and the result is taken.
// Queue pops go through the queue memory with a registered read.
// Reset (synchronous, i_rst_n low) clears queue pointers, registers, line
// counter and halt flag; program_length resets to 1.
module queue_machine_execute_unit_core
    import qmeu_pkg::*;
#(
    parameter int QueueDepth   = QueueDepthDef,
    parameter int ProgramLines = ProgramLinesDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [4:0]        i_action,
    input  logic [ValW-1:0]   i_immediate,
    input  logic [RegW-1:0]   i_reg_first,
    input  logic [RegW-1:0]   i_reg_second,
    input  logic [11:0]       i_target_line,
    input  logic              i_cfg_we,
    input  logic [LineW-1:0]  i_cfg_wdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_print_kind,
    output logic [ValW-1:0]   o_print_value,
    output logic [LineW-1:0]  o_next_line,
    output logic              o_halted,
    output logic              o_queue_overflow
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POPA = 3'd1;
    localparam logic [2:0] S_POPB = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [4:0]       r_act;
    logic [ValW-1:0]  r_imm;
    logic [RegW-1:0]  r_r1, r_r2;
    logic [11:0]      r_tgt;
    logic [ValW-1:0]  r_a, r_b, r_val;
    logic             r_a_ok, r_b_ok;
    logic [ValW-1:0]  r_regs [NumRegs];
    logic [LineW-1:0] r_line, r_plen;
    logic             r_halt;
    logic [1:0]       r_kind;
    logic [ValW-1:0]  r_pval;
    logic             r_ovf;
    logic             r_ovalid;

    logic             w_pop, w_push, w_empty, w_full;
    logic [ValW-1:0]  w_pop_data, w_qa, w_qb, w_rv1, w_rv2;
    t_alu_req         w_req;
    t_alu_rsp         w_rsp;
    logic             w_jump;
    logic [LineW-1:0] w_next, w_limit;

    qmeu_queue #(.QueueDepth(QueueDepth)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop      (w_pop),
        .i_push     (w_push),
        .i_push_data(r_val),
        .o_pop_data (w_pop_data),
        .o_empty    (w_empty),
        .o_full     (w_full)
    );

    qmeu_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_rv1 = (r_r1 < RegW'(NumRegs)) ? r_regs[r_r1] : '0;
    assign w_rv2 = (r_r2 < RegW'(NumRegs)) ? r_regs[r_r2] : '0;
    // popped values land the cycle after the pop
    assign w_qa  = r_a_ok ? w_pop_data : '0;
    assign w_qb  = r_b_ok ? w_pop_data : '0;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        w_pop         = 1'b0;
        w_push        = 1'b0;
        w_req.start   = 1'b0;
        w_req.op      = ALU_ADD;
        w_req.a       = r_a;
        w_req.b       = r_b;
        n_state       = r_state;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_POPA;
            S_POPA: begin
                if (r_halt) begin
                    n_state = S_FIN;
                end else if (r_act inside {[ACT_ADD:ACT_MOD], ACT_PUT, ACT_PRNQ, ACT_PRCQ}) begin
                    w_pop   = 1'b1;
                    n_state = (r_act inside {[ACT_ADD:ACT_MOD]}) ? S_POPB : S_FIN;
                end else if (r_act == ACT_PUSH || r_act == ACT_GET) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POPB: begin
                w_pop   = 1'b1;
                n_state = S_ALU;
            end
            S_ALU: begin
                w_req.start = 1'b1;
                w_req.a     = r_a;
                w_req.b     = w_qb;
                case (r_act)
                    ACT_ADD: w_req.op = ALU_ADD;
                    ACT_SUB: w_req.op = ALU_SUB;
                    ACT_MUL: w_req.op = ALU_MUL;
                    default: w_req.op = ALU_DIV;
                endcase
                n_state = S_WAIT;
            end
            S_WAIT: if (w_rsp.done) n_state = S_PUSH;
            S_PUSH: begin
                w_push  = 1'b1;
                n_state = S_FIN;
            end
            S_FIN:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_act)
            ACT_JMP: w_jump = 1'b1;
            ACT_JZ:  w_jump = (w_rv1 == '0);
            ACT_JEQ: w_jump = (w_rv1 == w_rv2);
            ACT_JGT: w_jump = (w_rv1 > w_rv2);
            default: w_jump = 1'b0;
        endcase
        w_next  = (w_jump ? {1'b0, r_tgt} : r_line) + 1'b1;
        w_limit = (r_plen > LineW'(ProgramLines)) ? LineW'(ProgramLines) : r_plen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_line   <= '0;
            r_halt   <= 1'b0;
            r_plen   <= LineW'(1);
            r_ovalid <= 1'b0;
            r_ovf    <= 1'b0;
            r_kind   <= PK_NONE;
            for (int i = 0; i < NumRegs; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_plen <= i_cfg_wdata;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_act <= i_action;
                    r_imm <= i_immediate;
                    r_r1  <= i_reg_first;
                    r_r2  <= i_reg_second;
                    r_tgt <= i_target_line;
                    r_ovf <= 1'b0;
                    r_kind <= PK_NONE;
                    r_pval <= '0;
                end
                S_POPA: begin
                    r_a_ok   <= !w_empty;
                    r_val    <= (r_act == ACT_PUSH) ? r_imm : w_rv1;
                end
                S_POPB: begin
                    r_a      <= w_qa;
                    r_b_ok   <= !w_empty;
                end
                S_WAIT: if (w_rsp.done) begin
                    // div and mod give 0 when either operand is 0
                    if ((r_act == ACT_DIV || r_act == ACT_MOD) && (r_a == '0 || r_b == '0))
                        r_val <= '0;
                    else if (r_act == ACT_MOD) r_val <= w_rsp.rem;
                    else r_val <= w_rsp.res;
                end
                S_PUSH: r_ovf <= w_full;
                S_FIN: begin
                    // single pops (put, queue prints) read back here
                    if (!r_halt) begin
                        case (r_act)
                            ACT_PUT: if (r_r1 < RegW'(NumRegs)) r_regs[r_r1] <= w_qa;
                            ACT_PRNQ: begin r_kind <= PK_NUM; r_pval <= w_qa; end
                            ACT_PRNR: begin r_kind <= PK_NUM; r_pval <= w_rv1; end
                            ACT_PRCQ: begin r_kind <= PK_CHR; r_pval <= {8'd0, w_qa[7:0]}; end
                            ACT_PRCR: begin r_kind <= PK_CHR; r_pval <= {8'd0, w_rv1[7:0]}; end
                            default: ;
                        endcase
                        r_line <= w_next;
                        if (r_act == ACT_QUIT || w_next >= w_limit) r_halt <= 1'b1;
                    end
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // divisor captured at ALU start is the second pop; keep it for the zero test
    always_ff @(posedge i_clk) begin
        if (r_state == S_ALU) r_b <= w_qb;
    end

    assign o_valid          = r_ovalid;
    assign o_print_kind     = r_kind;
    assign o_print_value    = r_pval;
    assign o_next_line      = r_line;
    assign o_halted         = r_halt;
    assign o_queue_overflow = r_ovf;

`include "queue_machine_execute_unit_core_macros.svh"

    `QM_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `QM_ASSERT_IMP(a_no_busy_out, i_clk, i_rst_n, o_valid, r_state == S_IDLE)
    `QM_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)

endmodule
